/* sv/tfcc_pkg.sv */
// Package for the temperature frame CRC check and conversion block.
// Holds the constants, register indexes and control structs shared by all files.
// Depends on nothing.
package tfcc_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned RAW_W    = 16;
  localparam int unsigned TEMP_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIVISOR = 2'd2;

  localparam logic signed [7:0] OFFSET_RESET  = -8'sd45;
  localparam logic [7:0]        GAIN_RESET    = 8'd175;
  localparam logic [15:0]       DIVISOR_RESET = 16'd65535;

  typedef struct packed {
    logic        start;
    logic [15:0] raw;
  } conv_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } conv_stat_t;

endpackage

/* sv/tfcc_if.sv */
// Channel interfaces of the temperature frame block: received bytes, results, configuration.
// Each carries valid, ready and its payload. Depends on tfcc_pkg.
interface tfcc_rx_if;
  import tfcc_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              frame_start;
  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface tfcc_res_if;
  import tfcc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature_centi;
  logic [RAW_W-1:0]         raw_value;
  logic                     check_ok;
  modport source (output valid, output temperature_centi, output raw_value, output check_ok,
                  input ready);
  modport sink (input valid, input temperature_centi, input raw_value, input check_ok,
                output ready);
endinterface

interface tfcc_cfg_if;
  import tfcc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

/* sv/tfcc_conv.sv */
// Serial conversion unit: shift-add multiply of gain*100 by the raw value, restoring
// division by the divisor one quotient bit per cycle, then offset and saturation.
// Depends on tfcc_pkg.
module tfcc_conv (
  input  logic                      clk,
  input  logic                      rst,
  input  tfcc_pkg::conv_req_t       req,
  input  logic signed [7:0]         offset_degrees,
  input  logic [7:0]                gain_degrees,
  input  logic [15:0]               raw_divisor,
  output tfcc_pkg::conv_stat_t      stat,
  output logic signed [tfcc_pkg::TEMP_W-1:0] temperature_centi
);
  import tfcc_pkg::*;

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_MUL  = 2'd1;
  localparam logic [1:0] C_DIV  = 2'd2;
  localparam logic [1:0] C_FIN  = 2'd3;

  logic [1:0]         cstate;
  logic [4:0]         cnt;
  logic [30:0]        acc;
  logic [15:0]        mplier;
  logic [15:0]        rem;
  logic [14:0]        g100;
  logic [15:0]        dvs;
  logic signed [15:0] off100;
  logic               done;

  logic [15:0]        off_ext;
  logic [16:0]        trial;
  logic [16:0]        diff;
  logic               ge;
  logic signed [32:0] sum;

  always_comb begin
    off_ext = {{8{offset_degrees[7]}}, offset_degrees};
    trial   = {rem, acc[30]};
    diff    = trial - {1'b0, dvs};
    ge      = trial >= {1'b0, dvs};
    sum     = $signed({2'b00, acc}) + $signed({{17{off100[15]}}, off100});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cstate <= C_IDLE;
      done   <= 1'b0;
    end else begin
      done <= (cstate == C_FIN);
      unique case (cstate)
        C_IDLE: begin
          if (req.start) begin
            cstate <= C_MUL;
          end
        end
        C_MUL: begin
          if (cnt == 5'd15) begin
            cstate <= C_DIV;
          end
        end
        C_DIV: begin
          if (cnt == 5'd30) begin
            cstate <= C_FIN;
          end
        end
        C_FIN: begin
          cstate <= C_IDLE;
        end
        default: begin
          cstate <= C_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cstate)
      C_IDLE: begin
        acc    <= '0;
        cnt    <= '0;
        mplier <= req.raw;
        g100   <= {1'b0, gain_degrees, 6'b0} + {2'b0, gain_degrees, 5'b0}
                  + {5'b0, gain_degrees, 2'b0};
        dvs    <= (raw_divisor == 16'd0) ? 16'd1 : raw_divisor;
        off100 <= $signed({off_ext[9:0], 6'b0}) + $signed({off_ext[10:0], 5'b0})
                  + $signed({off_ext[13:0], 2'b0});
      end
      C_MUL: begin
        acc    <= {acc[29:0], 1'b0} + (mplier[15] ? {16'b0, g100} : 31'd0);
        mplier <= {mplier[14:0], 1'b0};
        rem    <= '0;
        cnt    <= (cnt == 5'd15) ? 5'd0 : cnt + 5'd1;
      end
      C_DIV: begin
        rem <= ge ? diff[15:0] : trial[15:0];
        acc <= {acc[29:0], ge};
        cnt <= cnt + 5'd1;
      end
      C_FIN: begin
        if (sum > 33'sd32767) begin
          temperature_centi <= 16'sh7FFF;
        end else if (sum < -33'sd32768) begin
          temperature_centi <= 16'sh8000;
        end else begin
          temperature_centi <= sum[15:0];
        end
      end
      default: begin
        cnt <= '0;
      end
    endcase
  end

  assign stat = '{busy: (cstate != C_IDLE), done: done};

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    (cstate != C_IDLE) |-> !req.start)
    else $error("conversion started while busy");

  a_done_after_fin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cstate) == C_FIN)
    else $error("done without final step");

  a_mul_count: assert property (@(posedge clk) disable iff (rst)
    (cstate == C_MUL) |-> (cnt <= 5'd15))
    else $error("multiply step count out of range");

endmodule

/* sv/temp_frame_crc_check_convert_top.sv */
// Top level of the temperature frame block: frame tracking, bit-serial CRC-8, output register.
// Depends on tfcc_pkg, the channel interfaces in tfcc_if and the unit tfcc_conv.
//
//   Channel   Role   Payload                                        Transfer when
//   rx_chan   sink   rx_byte, frame_start                           valid && ready
//   res_chan  source temperature_centi, raw_value, check_ok         valid && ready
//   cfg_chan  sink   index, wdata (always ready)                    valid && ready
//
// A data byte is handled as the transfer, then 8 CRC steps, one bit per cycle.
// A check byte that fails the CRC goes from its transfer to S_OUT, then to the output
// register. A check byte that passes goes by way of S_CONV, which waits for the serial
// multiply (16 steps) and the restoring divide (31 steps) in tfcc_conv, and then S_OUT.
// Reset is synchronous; it restores the register defaults and restarts the frame.
// A waiting result does not stop the next bytes; only loading a new result waits for it.
module temp_frame_crc_check_convert_top (
  input logic        clk,
  input logic        rst,
  tfcc_rx_if.sink    rx_chan,
  tfcc_res_if.source res_chan,
  tfcc_cfg_if.sink   cfg_chan
);
  import tfcc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CRC  = 2'd1;
  localparam logic [1:0] S_CONV = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  localparam logic [1:0] POS_HIGH  = 2'd0;
  localparam logic [1:0] POS_LOW   = 2'd1;
  localparam logic [1:0] POS_CHECK = 2'd2;

  logic [1:0]        state;
  logic [1:0]        byte_position;
  logic [2:0]        crc_cnt;
  logic [7:0]        running_crc;
  logic [7:0]        high_byte_hold;
  logic [7:0]        low_byte_hold;
  logic              check_ok;
  logic signed [7:0] offset_degrees;
  logic [7:0]        gain_degrees;
  logic [15:0]       raw_divisor;
  logic              conv_start;
  conv_req_t         conv_req;
  conv_stat_t        conv_stat;
  logic signed [15:0] conv_temp;

  logic              rx_take;
  logic              out_load;
  logic [1:0]        pos;
  logic              crc_match;

  assign rx_chan.ready  = (state == S_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign rx_take        = rx_chan.valid && rx_chan.ready;
  assign out_load       = (state == S_OUT) && (!res_chan.valid || res_chan.ready);
  assign pos            = rx_chan.frame_start ? POS_HIGH : byte_position;
  assign crc_match      = (running_crc == rx_chan.rx_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_degrees <= OFFSET_RESET;
      gain_degrees   <= GAIN_RESET;
      raw_divisor    <= DIVISOR_RESET;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      unique case (cfg_chan.index)
        REG_OFFSET:  offset_degrees <= $signed(cfg_chan.wdata[7:0]);
        REG_GAIN:    gain_degrees   <= cfg_chan.wdata[7:0];
        REG_DIVISOR: raw_divisor    <= cfg_chan.wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      byte_position  <= POS_HIGH;
      running_crc    <= CRC_INIT;
      high_byte_hold <= '0;
      low_byte_hold  <= '0;
      crc_cnt        <= '0;
      conv_start     <= 1'b0;
      res_chan.valid <= 1'b0;
    end else begin
      conv_start <= rx_take && (pos == POS_CHECK) && crc_match;
      if (out_load) begin
        res_chan.valid <= 1'b1;
      end else if (res_chan.ready) begin
        res_chan.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (rx_take) begin
            crc_cnt <= '0;
            unique case (pos)
              POS_LOW: begin
                low_byte_hold <= rx_chan.rx_byte;
                running_crc   <= running_crc ^ rx_chan.rx_byte;
                byte_position <= POS_CHECK;
                state         <= S_CRC;
              end
              POS_CHECK: begin
                byte_position  <= POS_HIGH;
                running_crc    <= CRC_INIT;
                state          <= crc_match ? S_CONV : S_OUT;
              end
              default: begin
                high_byte_hold <= rx_chan.rx_byte;
                running_crc    <= CRC_INIT ^ rx_chan.rx_byte;
                byte_position  <= POS_LOW;
                state          <= S_CRC;
              end
            endcase
          end
        end
        S_CRC: begin
          running_crc <= running_crc[7] ? ({running_crc[6:0], 1'b0} ^ CRC_POLY)
                                        : {running_crc[6:0], 1'b0};
          crc_cnt     <= crc_cnt + 3'd1;
          if (crc_cnt == 3'd7) begin
            state <= S_IDLE;
          end
        end
        S_CONV: begin
          if (conv_stat.done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rx_take && pos == POS_CHECK) begin
      check_ok <= crc_match;
    end
    if (out_load) begin
      res_chan.temperature_centi <= check_ok ? conv_temp : 16'sd0;
      res_chan.raw_value         <= {high_byte_hold, low_byte_hold};
      res_chan.check_ok          <= check_ok;
    end
  end

  assign conv_req = '{start: conv_start, raw: {high_byte_hold, low_byte_hold}};

  tfcc_conv u_conv (
    .clk               (clk),
    .rst               (rst),
    .req               (conv_req),
    .offset_degrees    (offset_degrees),
    .gain_degrees      (gain_degrees),
    .raw_divisor       (raw_divisor),
    .stat              (conv_stat),
    .temperature_centi (conv_temp)
  );

  a_fail_goes_out: assert property (@(posedge clk) disable iff (rst)
    (rx_take && pos == POS_CHECK && !crc_match) |=> (state == S_OUT))
    else $error("failed check byte did not go straight to the output");

  a_fail_zero_temp: assert property (@(posedge clk) disable iff (rst)
    (res_chan.valid && !res_chan.check_ok) |-> (res_chan.temperature_centi == 16'sd0))
    else $error("failed frame carries a non-zero temperature");

  a_busy_in_conv: assert property (@(posedge clk) disable iff (rst)
    conv_stat.busy |-> (state == S_CONV))
    else $error("conversion running outside its state");

  a_pos_legal: assert property (@(posedge clk) disable iff (rst)
    byte_position != 2'd3)
    else $error("byte position reached the unused code");

endmodule
